// ===== sv/spc_pkg.sv =====
// Shared types and constants for the stepper position controller.
package spc_pkg;

  localparam int unsigned ADDR_W = 3;

  localparam logic [7:0]  FAST_DIV_RESET = 8'd2;
  localparam logic [7:0]  SLOW_DIV_RESET = 8'd16;
  localparam logic [31:0] IDLE_MAX       = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_MOVE   = 2'd1,
    OP_STOP   = 2'd2,
    OP_PRESET = 2'd3
  } op_t;

  typedef enum logic {
    REG_FAST_DIV = 1'b0,
    REG_SLOW_DIV = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] position;
    logic        fast;
  } item_t;

  typedef struct packed {
    logic        step_pulse;
    logic        direction;
    logic [15:0] position_now;
    logic [15:0] target_now;
    logic        moving;
    logic [31:0] idle_ticks;
  } result_t;

endpackage

// ===== sv/spc_regs.sv =====
// APB-style configuration registers: fast and slow step divisors.
module spc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [7:0]                 fast_divisor,
  output logic [7:0]                 slow_divisor
);
  import spc_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_divisor <= FAST_DIV_RESET;
      slow_divisor <= SLOW_DIV_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_FAST_DIV: fast_divisor <= pwdata[7:0];
        REG_SLOW_DIV: slow_divisor <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FAST_DIV: prdata = {24'd0, fast_divisor};
      REG_SLOW_DIV: prdata = {24'd0, slow_divisor};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/spc_core.sv =====
// Controller state and its combinational update for one item.
module spc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  spc_pkg::item_t   item,
  input  logic [7:0]       fast_divisor,
  input  logic [7:0]       slow_divisor,
  output spc_pkg::result_t res
);
  import spc_pkg::*;

  logic [15:0] current_position, current_position_next;
  logic [15:0] target_position, target_position_next;
  logic        fast_selected, fast_selected_next;
  logic [7:0]  tick_divider, tick_divider_next;
  logic [31:0] idle_counter, idle_counter_next;
  logic        direction_line, direction_line_next;
  logic        pulse;
  logic [7:0]  divisor;
  logic [7:0]  reload;

  assign divisor = fast_selected ? fast_divisor : slow_divisor;
  assign reload  = (divisor == 8'd0) ? 8'd0 : divisor - 8'd1;

  always_comb begin
    current_position_next = current_position;
    target_position_next  = target_position;
    fast_selected_next    = fast_selected;
    tick_divider_next     = tick_divider;
    idle_counter_next     = idle_counter;
    direction_line_next   = direction_line;
    pulse                 = 1'b0;
    case (item.operation)
      OP_TICK: begin
        if (current_position == target_position) begin
          if (idle_counter != IDLE_MAX) idle_counter_next = idle_counter + 32'd1;
        end else if (tick_divider == 8'd0) begin
          if (target_position > current_position) begin
            direction_line_next   = 1'b1;
            current_position_next = current_position + 16'd1;
          end else begin
            direction_line_next   = 1'b0;
            current_position_next = current_position - 16'd1;
          end
          pulse             = 1'b1;
          idle_counter_next = 32'd0;
          tick_divider_next = reload;
        end else begin
          tick_divider_next = tick_divider - 8'd1;
        end
      end
      OP_MOVE: begin
        target_position_next = item.position;
        fast_selected_next   = item.fast;
      end
      OP_STOP: target_position_next = current_position;
      OP_PRESET: begin
        current_position_next = item.position;
        target_position_next  = item.position;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_position <= 16'd0;
      target_position  <= 16'd0;
      fast_selected    <= 1'b0;
      tick_divider     <= 8'd0;
      idle_counter     <= 32'd0;
      direction_line   <= 1'b0;
    end else if (advance) begin
      current_position <= current_position_next;
      target_position  <= target_position_next;
      fast_selected    <= fast_selected_next;
      tick_divider     <= tick_divider_next;
      idle_counter     <= idle_counter_next;
      direction_line   <= direction_line_next;
    end
  end

  always_comb begin
    res.step_pulse   = pulse;
    res.direction    = direction_line_next;
    res.position_now = current_position_next;
    res.target_now   = target_position_next;
    res.moving       = (current_position_next != target_position_next);
    res.idle_ticks   = idle_counter_next;
  end

endmodule

// ===== sv/stepper_position_controller.sv =====
// Stepper step/direction position controller, top level.
// An input register and a result register separate the channels; an accepted item
// passes through them in that order. Throughput: one item per cycle while out_stall
// does not hold the result register; the state updates as an item enters it.
// Reset (rst, synchronous): position, target, divider, idle count and direction
// clear, slow speed is selected, divisors return to 2 (fast) and 16 (slow).
module stepper_position_controller (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 operation,
  input  logic [15:0]                position,
  input  logic                       fast,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       step_pulse,
  output logic                       direction,
  output logic [15:0]                position_now,
  output logic [15:0]                target_now,
  output logic                       moving,
  output logic [31:0]                idle_ticks,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import spc_pkg::*;

  logic       fast_divisor_q;
  logic [7:0] fast_divisor;
  logic [7:0] slow_divisor;
  logic       s1_valid;
  item_t      s1_item;
  logic       advance;
  logic       in_take;
  result_t    res;
  result_t    out_q;

  spc_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fast_divisor (fast_divisor),
    .slow_divisor (slow_divisor)
  );

  assign fast_divisor_q = 1'b0;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.operation <= op_t'(operation);
      s1_item.position  <= position;
      s1_item.fast      <= fast;
    end
  end

  spc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (s1_item),
    .fast_divisor (fast_divisor | {7'd0, fast_divisor_q}),
    .slow_divisor (slow_divisor),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign step_pulse   = out_q.step_pulse;
  assign direction    = out_q.direction;
  assign position_now = out_q.position_now;
  assign target_now   = out_q.target_now;
  assign moving       = out_q.moving;
  assign idle_ticks   = out_q.idle_ticks;

endmodule

// ===== test/tb_stepper_position_controller.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the stepper position controller.
module tb_stepper_position_controller;
  import spc_pkg::*;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          operation;
  logic [15:0]         position;
  logic                fast;
  logic                out_valid;
  logic                out_stall;
  logic                step_pulse;
  logic                direction;
  logic [15:0]         position_now;
  logic [15:0]         target_now;
  logic                moving;
  logic [31:0]         idle_ticks;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  stepper_position_controller u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .position(position), .fast(fast),
    .out_valid(out_valid), .out_stall(out_stall),
    .step_pulse(step_pulse), .direction(direction),
    .position_now(position_now), .target_now(target_now),
    .moving(moving), .idle_ticks(idle_ticks),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // controller state as predicted
  logic [7:0]  fast_div;
  logic [7:0]  slow_div;
  logic [15:0] cur_pos;
  logic [15:0] tgt_pos;
  logic        fast_sel;
  logic [7:0]  div_cnt;
  logic [31:0] idle_cnt;
  logic        dir_line;

  result_t pending_status[$];
  int      err_cnt = 0;
  int      items_sent = 0;
  int      steps_seen = 0;
  int      settings_run = 0;
  int      op_count[4] = '{0, 0, 0, 0};
  bit      idle_on = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic result_t advance_controller(op_t op, logic [15:0] pos, logic f);
    result_t    r;
    logic [7:0] d;
    r.step_pulse = 1'b0;
    case (op)
      OP_TICK: begin
        if (cur_pos == tgt_pos) begin
          if (idle_cnt != IDLE_MAX) idle_cnt = idle_cnt + 1;
        end else if (div_cnt == 8'd0) begin
          dir_line = (tgt_pos > cur_pos);
          cur_pos = dir_line ? cur_pos + 16'd1 : cur_pos - 16'd1;
          r.step_pulse = 1'b1;
          idle_cnt = '0;
          d = fast_sel ? fast_div : slow_div;
          div_cnt = (d == 8'd0) ? 8'd0 : d - 8'd1;
        end else begin
          div_cnt = div_cnt - 8'd1;
        end
      end
      OP_MOVE: begin
        tgt_pos = pos;
        fast_sel = f;
      end
      OP_STOP: tgt_pos = cur_pos;
      OP_PRESET: begin
        cur_pos = pos;
        tgt_pos = pos;
      end
      default: ;
    endcase
    r.direction    = dir_line;
    r.position_now = cur_pos;
    r.target_now   = tgt_pos;
    r.moving       = (cur_pos != tgt_pos);
    r.idle_ticks   = idle_cnt;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        $error("result with no item pending");
        err_cnt++;
      end else begin
        want = pending_status.pop_front();
        check_field("step_pulse", 32'(want.step_pulse), 32'(step_pulse));
        check_field("direction", 32'(want.direction), 32'(direction));
        check_field("position_now", 32'(want.position_now), 32'(position_now));
        check_field("target_now", 32'(want.target_now), 32'(target_now));
        check_field("moving", 32'(want.moving), 32'(moving));
        check_field("idle_ticks", want.idle_ticks, idle_ticks);
        if (step_pulse === 1'b1) steps_seen++;
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(op_t op, logic [15:0] pos, logic f);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    position  <= pos;
    fast      <= f;
    do @(posedge clk); while (in_stall);
    pending_status.push_back(advance_controller(op, pos, f));
    items_sent++;
    op_count[op]++;
  endtask

  task automatic tick();
    send_item(OP_TICK, 16'($urandom), 1'($urandom));
  endtask

  // input quiet, every result back, then a margin
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_reg(reg_idx_t r, logic [7:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field(r.name(), 32'(want), prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(reg_idx_t r, logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {24'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (r == REG_FAST_DIV) fast_div = value;
    else slow_div = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    read_reg(r, value);
  endtask

  task automatic test_directed();
    read_reg(REG_FAST_DIV, FAST_DIV_RESET);
    read_reg(REG_SLOW_DIV, SLOW_DIV_RESET);
    tick();
    tick();
    send_item(OP_MOVE, 16'd4, 1'b1);
    repeat (7) tick();
    send_item(OP_MOVE, 16'd0, 1'b1);
    tick();
    send_item(OP_STOP, 16'hffff, 1'b1);
    tick();
    send_item(OP_PRESET, 16'hffff, 1'b1);
    send_item(OP_MOVE, 16'hfffe, 1'b0);
    repeat (3) tick();
    send_item(OP_PRESET, 16'h0000, 1'b0);
    send_item(OP_MOVE, 16'hffff, 1'b1);
    repeat (3) tick();
    send_item(OP_STOP, 16'h0000, 1'b0);
    tick();
  endtask

  task automatic run_random(int n);
    int          stop_at;
    int          offset;
    logic [15:0] dest;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          offset = $urandom_range(0, 12);
          dest = $urandom_range(0, 1) ? cur_pos + 16'(offset) : cur_pos - 16'(offset);
          if ($urandom_range(0, 15) == 0) dest = 16'($urandom);
          send_item(OP_MOVE, dest, 1'($urandom));
          repeat ($urandom_range(1, 40)) tick();
          if ($urandom_range(0, 3) == 0) begin
            send_item(OP_STOP, 16'($urandom), 1'($urandom));
            repeat ($urandom_range(0, 4)) tick();
          end
        end
        7, 8: begin
          send_item(OP_PRESET, 16'($urandom), 1'($urandom));
          repeat ($urandom_range(0, 3)) tick();
        end
        default: begin
          repeat ($urandom_range(1, 5))
            send_item(op_t'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
        end
      endcase
    end
  endtask

  task automatic test_divisor_setting(logic [7:0] fdiv, logic [7:0] sdiv, int n);
    wait_idle();
    write_reg(REG_FAST_DIV, fdiv);
    write_reg(REG_SLOW_DIV, sdiv);
    settings_run++;
    run_random(n);
  endtask

  task automatic test_steady_stream(int n);
    wait_idle();
    idle_on = 1'b0;
    write_reg(REG_FAST_DIV, FAST_DIV_RESET);
    write_reg(REG_SLOW_DIV, SLOW_DIV_RESET);
    settings_run++;
    run_random(n);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = OP_TICK;
    position  = '0;
    fast      = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    fast_div  = FAST_DIV_RESET;
    slow_div  = SLOW_DIV_RESET;
    cur_pos   = '0;
    tgt_pos   = '0;
    fast_sel  = 1'b0;
    div_cnt   = '0;
    idle_cnt  = '0;
    dir_line  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_divisor_setting(8'd1, 8'd255, 300);
    test_divisor_setting(8'd255, 8'd1, 300);
    test_divisor_setting(8'd0, 8'd0, 200);
    test_divisor_setting(8'd3, 8'd7, 350);
    test_steady_stream(300);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("summary: %0d items (%0d tick, %0d move, %0d stop, %0d preset), %0d steps",
             items_sent, op_count[OP_TICK], op_count[OP_MOVE], op_count[OP_STOP],
             op_count[OP_PRESET], steps_seen);
    $display("summary: %0d divisor settings incl. 0, 1 and 255, reset values read back",
             settings_run);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== stepper_position_controller.f =====
sv/spc_pkg.sv
sv/spc_regs.sv
sv/spc_core.sv
sv/stepper_position_controller.sv
test/tb_stepper_position_controller.sv
